// File: hdl/fcs_pkg.sv
// shared types and constants of the filled circle span generator
package fcs_pkg;

  localparam int COORD_W  = 12;
  localparam int RADIUS_W = 6;
  localparam int COLOR_W  = 32;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 9;
  localparam int MASK_W   = 4;

  // internal arithmetic widths
  localparam int STEP_W = RADIUS_W + 1;
  localparam int ERR_W  = 12;
  localparam int CALC_W = COORD_W + 2;

  // results per circle are capped here
  localparam int RESULT_LIMIT = 46;
  localparam int COUNT_W      = $clog2(RESULT_LIMIT + 1);

  localparam int QUEUE_DEPTH = 2;

  // row_mask bit positions
  localparam int MASK_WIDE_BELOW   = 0;
  localparam int MASK_WIDE_ABOVE   = 1;
  localparam int MASK_NARROW_BELOW = 2;
  localparam int MASK_NARROW_ABOVE = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [RADIUS_W-1:0]       radius;
    logic [COLOR_W-1:0]        circle_color;
  } cmd_t;

  // command after radius saturation
  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [RADIUS_W-1:0]       radius;
    logic [COLOR_W-1:0]        color;
  } job_t;

  typedef struct packed {
    logic [COL_W-1:0]   wide_start;
    logic [COL_W-1:0]   wide_end;
    logic [ROW_W-1:0]   wide_row_below;
    logic [ROW_W-1:0]   wide_row_above;
    logic [COL_W-1:0]   narrow_start;
    logic [COL_W-1:0]   narrow_end;
    logic [ROW_W-1:0]   narrow_row_below;
    logic [ROW_W-1:0]   narrow_row_above;
    logic [MASK_W-1:0]  row_mask;
    logic [COLOR_W-1:0] fill_color;
    logic               last;
  } span_t;

endpackage

// File: hdl/fcs_stream_if.sv
// valid/ready stream interface carrying one payload per transaction
interface fcs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/fcs_cmd_front.sv
// command front end: accepts circle commands and saturates the radius
module fcs_cmd_front #(
  parameter int MAX_RADIUS = 63
) (
  fcs_stream_if.sink         cmd,
  output logic               job_valid,
  input  logic               job_ready,
  output fcs_pkg::job_t      job
);

  logic radius_over;

  assign radius_over = {2'b00, cmd.payload.radius} > 8'(MAX_RADIUS);

  assign cmd.ready  = job_ready;
  assign job_valid  = cmd.valid;

  always_comb begin
    job.origin_x = cmd.payload.origin_x;
    job.origin_y = cmd.payload.origin_y;
    job.color    = cmd.payload.circle_color;
    job.radius   = radius_over ? fcs_pkg::RADIUS_W'(MAX_RADIUS) : cmd.payload.radius;
  end

endmodule

// File: hdl/fcs_job_queue.sv
// short register queue between the command front end and the span engine
module fcs_job_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  fcs_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output fcs_pkg::job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fcs_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign push_ready = fill != CNT_W'(DEPTH);
  assign pop_valid  = fill != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/fcs_span_engine.sv
// midpoint engine: one span pair per unstalled cycle into an output register
module fcs_span_engine #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  fcs_pkg::job_t job,
  fcs_stream_if.source  span
);

  localparam int CW = fcs_pkg::CALC_W;
  localparam logic signed [CW-1:0] COL_MAX = CW'(FRAME_WIDTH - 1);
  localparam logic signed [CW-1:0] ROW_MAX = CW'(FRAME_HEIGHT - 1);

  // iteration state
  logic                                busy;
  logic signed [fcs_pkg::COORD_W-1:0]  cx;
  logic signed [fcs_pkg::COORD_W-1:0]  cy;
  logic [fcs_pkg::COLOR_W-1:0]         color;
  logic [fcs_pkg::RADIUS_W-1:0]        x;
  logic [fcs_pkg::STEP_W-1:0]          y;
  logic signed [fcs_pkg::ERR_W-1:0]    err;
  logic [fcs_pkg::COUNT_W-1:0]         count;

  logic                                out_valid;
  fcs_pkg::span_t                      out_data;
  fcs_pkg::span_t                      out_next;

  logic                                advance;
  logic                                done;
  logic [fcs_pkg::COUNT_W-1:0]         count_next;

  logic signed [CW-1:0] cx_w, cy_w, xs, ys;
  logic signed [CW-1:0] w_lo, w_hi, n_lo, n_hi;
  logic signed [CW-1:0] ws, we, ns, ne;
  logic signed [CW-1:0] r_wb, r_wa, r_nb, r_na;
  logic                 w_span, n_span;
  logic                 b0, b1, b2, b3, w_any, n_any;

  logic signed [CW-1:0] y1, e1, e2, x1, dec_test;
  logic                 x_step;

  assign advance   = busy && (!out_valid || span.ready);
  assign job_ready = !busy;

  assign span.valid   = out_valid;
  assign span.payload = out_data;

  // spans and rows of the current iteration
  always_comb begin
    cx_w = {{(CW - fcs_pkg::COORD_W){cx[fcs_pkg::COORD_W-1]}}, cx};
    cy_w = {{(CW - fcs_pkg::COORD_W){cy[fcs_pkg::COORD_W-1]}}, cy};
    xs   = {{(CW - fcs_pkg::RADIUS_W){1'b0}}, x};
    ys   = {{(CW - fcs_pkg::STEP_W){1'b0}}, y};

    w_lo = cx_w - xs;
    w_hi = cx_w + xs;
    n_lo = cx_w - ys;
    n_hi = cx_w + ys;

    ws = (w_lo < 0) ? '0 : w_lo;
    we = (w_hi > COL_MAX) ? COL_MAX : w_hi;
    ns = (n_lo < 0) ? '0 : n_lo;
    ne = (n_hi > COL_MAX) ? COL_MAX : n_hi;
    w_span = ws <= we;
    n_span = ns <= ne;

    r_wb = cy_w + ys;
    r_wa = cy_w - ys;
    r_nb = cy_w + xs;
    r_na = cy_w - xs;

    b0 = w_span && (r_wb >= 0) && (r_wb <= ROW_MAX);
    b1 = w_span && (r_wa >= 0) && (r_wa <= ROW_MAX);
    b2 = n_span && (r_nb >= 0) && (r_nb <= ROW_MAX);
    b3 = n_span && (r_na >= 0) && (r_na <= ROW_MAX);
    w_any = b0 || b1;
    n_any = b2 || b3;
  end

  // midpoint step and loop end
  always_comb begin
    y1       = ys + CW'(1);
    e1       = {{(CW - fcs_pkg::ERR_W){err[fcs_pkg::ERR_W-1]}}, err} + CW'(1) + (y1 <<< 1);
    dec_test = ((e1 - xs) <<< 1) + CW'(1);
    x_step   = dec_test > 0;
    x1       = x_step ? xs - CW'(1) : xs;
    e2       = x_step ? e1 + CW'(1) - (x1 <<< 1) : e1;
    count_next = count + 1'b1;
    done     = (x1 < y1) || (count_next == fcs_pkg::COUNT_W'(fcs_pkg::RESULT_LIMIT));
  end

  always_comb begin
    out_next.wide_start       = w_any ? ws[fcs_pkg::COL_W-1:0] : '0;
    out_next.wide_end         = w_any ? we[fcs_pkg::COL_W-1:0] : '0;
    out_next.wide_row_below   = b0 ? r_wb[fcs_pkg::ROW_W-1:0] : '0;
    out_next.wide_row_above   = b1 ? r_wa[fcs_pkg::ROW_W-1:0] : '0;
    out_next.narrow_start     = n_any ? ns[fcs_pkg::COL_W-1:0] : '0;
    out_next.narrow_end       = n_any ? ne[fcs_pkg::COL_W-1:0] : '0;
    out_next.narrow_row_below = b2 ? r_nb[fcs_pkg::ROW_W-1:0] : '0;
    out_next.narrow_row_above = b3 ? r_na[fcs_pkg::ROW_W-1:0] : '0;
    out_next.row_mask         = '0;
    out_next.row_mask[fcs_pkg::MASK_WIDE_BELOW]   = b0;
    out_next.row_mask[fcs_pkg::MASK_WIDE_ABOVE]   = b1;
    out_next.row_mask[fcs_pkg::MASK_NARROW_BELOW] = b2;
    out_next.row_mask[fcs_pkg::MASK_NARROW_ABOVE] = b3;
    out_next.fill_color       = color;
    out_next.last             = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!busy && job_valid) begin
        busy <= 1'b1;
      end else if (advance && done) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (span.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && job_valid) begin
      cx    <= job.origin_x;
      cy    <= job.origin_y;
      color <= job.color;
      x     <= job.radius;
      y     <= '0;
      err   <= '0;
      count <= '0;
    end else if (advance) begin
      x     <= x1[fcs_pkg::RADIUS_W-1:0];
      y     <= y1[fcs_pkg::STEP_W-1:0];
      err   <= e2[fcs_pkg::ERR_W-1:0];
      count <= count_next;
    end
    if (advance) begin
      out_data <= out_next;
    end
  end

endmodule

// File: hdl/filled_circle_span_generator.sv
// top level of the filled circle span generator
//
// cmd channel: one circle per transaction (signed centre, radius 0..63, colour).
// span channel: one transaction per midpoint iteration, carrying the wide span
// (origin_x -/+ x on rows origin_y +/- y) and the narrow span (origin_x -/+ y
// on rows origin_y +/- x), clipped to the frame, with a 4-bit row mask.
// masked-off rows and spans read zero; last marks the final result of a circle
//
// first result: via the queue, the engine's registers and the output register
// throughput: a circle of radius r gives about r/sqrt(2)+1 results (at most 46),
// one per cycle from the iteration engine while span is not stalled; the engine
// loads the next circle from the queue only once the last one is done; a radius
// of 63 gives 45 results
// the engine's single step unit sets this rate
//
// a two-entry command queue lets cmd keep accepting while the engine works
// if the receiver stalls, the output register holds its result and the engine
// pauses; once the queue fills, cmd.ready drops
// reset empties the queue and the output register and idles the engine; data registers are not reset
module filled_circle_span_generator #(
  parameter int FRAME_WIDTH  = 640,
  parameter int FRAME_HEIGHT = 480,
  parameter int MAX_RADIUS   = 63
) (
  input  logic         clk,
  input  logic         rst,
  fcs_stream_if.sink   cmd,
  fcs_stream_if.source span
);

  // front end to queue
  logic          front_valid;
  logic          front_ready;
  fcs_pkg::job_t front_job;

  // queue to engine
  logic          queued_valid;
  logic          queued_ready;
  fcs_pkg::job_t queued_job;

  // accept and saturate the command
  fcs_cmd_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .cmd       (cmd),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  // decouple the command side from the iteration engine
  fcs_job_queue #(
    .DEPTH (fcs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (queued_valid),
    .pop_ready  (queued_ready),
    .pop_data   (queued_job)
  );

  // midpoint loop, clipping and the registered result
  fcs_span_engine #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queued_valid),
    .job_ready (queued_ready),
    .job       (queued_job),
    .span      (span)
  );

endmodule

// File: hdl/fcs_checker.sv
// port-level checks on the span output, bound to the top level
module fcs_checker (
  input logic           clk,
  input logic           rst,
  input logic           span_valid,
  input logic           span_ready,
  input fcs_pkg::span_t span_data
);

  // output is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !span_valid)
    else $error("span valid right after reset");

  // a row whose mask bit is clear reads zero
  a_masked_rows_zero: assert property (@(posedge clk) disable iff (rst)
    span_valid |->
      (span_data.row_mask[fcs_pkg::MASK_WIDE_BELOW]   || span_data.wide_row_below == '0) &&
      (span_data.row_mask[fcs_pkg::MASK_WIDE_ABOVE]   || span_data.wide_row_above == '0) &&
      (span_data.row_mask[fcs_pkg::MASK_NARROW_BELOW] || span_data.narrow_row_below == '0) &&
      (span_data.row_mask[fcs_pkg::MASK_NARROW_ABOVE] || span_data.narrow_row_above == '0))
    else $error("masked row not zero");

  // a span with no valid row reads zero
  a_masked_spans_zero: assert property (@(posedge clk) disable iff (rst)
    span_valid |->
      ((span_data.row_mask[fcs_pkg::MASK_WIDE_BELOW] ||
        span_data.row_mask[fcs_pkg::MASK_WIDE_ABOVE] ||
        (span_data.wide_start == '0 && span_data.wide_end == '0)) &&
       (span_data.row_mask[fcs_pkg::MASK_NARROW_BELOW] ||
        span_data.row_mask[fcs_pkg::MASK_NARROW_ABOVE] ||
        (span_data.narrow_start == '0 && span_data.narrow_end == '0))))
    else $error("masked span not zero");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    span_valid && !span_ready |=> span_valid && $stable(span_data))
    else $error("stalled result changed");

endmodule

bind filled_circle_span_generator fcs_checker u_fcs_checker (
  .clk        (clk),
  .rst        (rst),
  .span_valid (span.valid),
  .span_ready (span.ready),
  .span_data  (span.payload)
);
